FILE: rtl/dwpd_pkg.sv
package dwpd_pkg;

    localparam int POS_W      = 24;
    localparam int OUT_W      = 24;
    localparam int STAT_W     = 16;
    localparam int VAL_W      = STAT_W + 1;
    localparam int WIN_W      = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SWING       = 3'd0,
        CFG_THRESHOLD_SHORT = 3'd1,
        CFG_THRESHOLD_LONG  = 3'd2,
        CFG_WINDOW_SHORT    = 3'd3,
        CFG_WINDOW_LONG     = 3'd4
    } cfg_index_t;

    localparam logic [STAT_W-1:0] MIN_SWING_RST       = 16'd256;
    localparam logic [STAT_W-1:0] THRESHOLD_SHORT_RST = 16'd1101;
    localparam logic [STAT_W-1:0] THRESHOLD_LONG_RST  = 16'd658;
    localparam logic [WIN_W-1:0]  WINDOW_SHORT_RST    = 8'd3;
    localparam logic [WIN_W-1:0]  WINDOW_LONG_RST     = 8'd6;

    typedef struct packed {
        logic [STAT_W-1:0] min_swing;
        logic [STAT_W-1:0] threshold_short;
        logic [STAT_W-1:0] threshold_long;
        logic [WIN_W-1:0]  window_short;
        logic [WIN_W-1:0]  window_long;
    } dwpd_cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        logic             in_peak;
        logic             confirmed;
    } dwpd_track_t;

    // all-ones value marks "no minimum seen yet"
    localparam dwpd_track_t TRACK_RESET = '{
        value:     {VAL_W{1'b1}},
        position:  {POS_W{1'b0}},
        in_peak:   1'b0,
        confirmed: 1'b0
    };

endpackage

FILE: rtl/dwpd_regs.sv
module dwpd_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [dwpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dwpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output dwpd_pkg::dwpd_cfg_t               cfg
);
    import dwpd_pkg::*;

    dwpd_cfg_t cfg_reg;
    dwpd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_SWING:       cfg_next.min_swing       = cfg_wdata;
                CFG_THRESHOLD_SHORT: cfg_next.threshold_short = cfg_wdata;
                CFG_THRESHOLD_LONG:  cfg_next.threshold_long  = cfg_wdata;
                CFG_WINDOW_SHORT:    cfg_next.window_short    = cfg_wdata[WIN_W-1:0];
                CFG_WINDOW_LONG:     cfg_next.window_long     = cfg_wdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_swing       <= MIN_SWING_RST;
            cfg_reg.threshold_short <= THRESHOLD_SHORT_RST;
            cfg_reg.threshold_long  <= THRESHOLD_LONG_RST;
            cfg_reg.window_short    <= WINDOW_SHORT_RST;
            cfg_reg.window_long     <= WINDOW_LONG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dwpd_detector.sv
module dwpd_detector (
    input  logic [dwpd_pkg::STAT_W-1:0] cur,
    input  dwpd_pkg::dwpd_track_t       trk_in,
    input  logic                        skip,
    input  logic [dwpd_pkg::STAT_W-1:0] threshold,
    input  logic [dwpd_pkg::WIN_W-1:0]  window,
    input  logic [dwpd_pkg::STAT_W-1:0] min_swing,
    input  logic [dwpd_pkg::POS_W-1:0]  pos,
    output dwpd_pkg::dwpd_track_t       trk_out,
    output logic                        emit,
    output logic                        over_thr
);
    import dwpd_pkg::*;

    logic [VAL_W-1:0] cur_ext;
    logic [VAL_W-1:0] ph_ext;
    logic             rise;
    logic [VAL_W-1:0] val_upd;
    logic [POS_W-1:0] pos_upd;
    logic             above;
    logic             drop;
    logic             conf_upd;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] half_win;

    assign cur_ext  = {1'b0, cur};
    assign ph_ext   = {1'b0, min_swing};
    assign rise     = cur_ext > trk_in.value;
    // follow the open peak upward
    assign val_upd  = rise ? cur_ext : trk_in.value;
    assign pos_upd  = rise ? pos : trk_in.position;
    assign above    = val_upd > {1'b0, threshold};
    assign drop     = (val_upd > cur_ext) && ((val_upd - cur_ext) > ph_ext);
    assign conf_upd = trk_in.confirmed || (drop && above);
    assign span     = pos - pos_upd;
    assign half_win = POS_W'(window >> 1);

    always_comb begin
        trk_out  = trk_in;
        emit     = 1'b0;
        over_thr = 1'b0;
        if (!skip) begin
            if (!trk_in.in_peak) begin
                if (cur_ext < trk_in.value) begin
                    trk_out.value = cur_ext;
                end else if ((cur_ext - trk_in.value) > ph_ext) begin
                    trk_out.value    = cur_ext;
                    trk_out.position = pos;
                    trk_out.in_peak  = 1'b1;
                end
            end else begin
                over_thr          = above;
                trk_out.value     = val_upd;
                trk_out.position  = pos_upd;
                trk_out.confirmed = conf_upd;
                // release the peak once far enough behind; keep its position
                if (conf_upd && (span > half_win)) begin
                    emit              = 1'b1;
                    trk_out.in_peak   = 1'b0;
                    trk_out.value     = cur_ext;
                    trk_out.confirmed = 1'b0;
                end
            end
        end
    end

endmodule

FILE: rtl/dual_window_peak_detector.sv
// Dual-window peak detector. Each transfer on the s_ channel carries one sample
// position's short- and long-window statistics (unsigned Q8.8) and a new-read
// flag that restarts the position count and both detectors before the sample.
// The block takes one sample per clock cycle unless a held result stalls it: a
// sample sits in the input register, and once it advances the detector update
// (both detectors and the long-window mask, chained in one pass) writes the
// state and, when a peak is released, the result register, so a peak position
// reaches m_ through the input register and then the result register. That
// state update loop sets the rate; a held result stalls intake only once the
// input register is also full. Configuration is written through
// cfg_we/cfg_index/cfg_wdata; the user must do so only while the block is idle,
// which the block does not enforce; indexes past the last register are ignored.
module dual_window_peak_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dwpd_pkg::STAT_W-1:0]     s_stat_short,
    input  logic [dwpd_pkg::STAT_W-1:0]     s_stat_long,
    input  logic                            s_new_read,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dwpd_pkg::OUT_W-1:0]      m_peak_position,
    input  logic                            cfg_we,
    input  logic [dwpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dwpd_pkg::*;

    dwpd_cfg_t cfg;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [STAT_W-1:0] in_short_reg;
    logic [STAT_W-1:0] in_long_reg;
    logic              in_new_read_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_pos_reg;
    logic [OUT_W-1:0]  out_pos_next;

    logic [POS_W-1:0]  sample_index_reg;
    logic [POS_W-1:0]  sample_index_next;
    logic [POS_W-1:0]  mask_until_reg;
    logic [POS_W-1:0]  mask_until_next;
    dwpd_track_t       trk_short_reg;
    dwpd_track_t       trk_short_next;
    dwpd_track_t       trk_long_reg;
    dwpd_track_t       trk_long_next;

    logic              advance;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  mask_eff;
    dwpd_track_t       short_in;
    dwpd_track_t       long_eff;
    dwpd_track_t       long_in;
    logic              emit_short;
    logic              emit_long;
    logic              over_short;
    logic              over_long;
    logic [POS_W:0]    mask_sum;
    logic [POS_W-1:0]  mask_sat;

    dwpd_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // new read: start from reset state before this sample
    assign pos      = in_new_read_reg ? '0 : sample_index_reg;
    assign mask_eff = in_new_read_reg ? '0 : mask_until_reg;
    assign short_in = in_new_read_reg ? TRACK_RESET : trk_short_reg;
    assign long_eff = in_new_read_reg ? TRACK_RESET : trk_long_reg;

    dwpd_detector u_short (
        .cur         (in_short_reg),
        .trk_in      (short_in),
        .skip        (pos == '0),
        .threshold   (cfg.threshold_short),
        .window      (cfg.window_short),
        .min_swing   (cfg.min_swing),
        .pos         (pos),
        .trk_out     (trk_short_next),
        .emit        (emit_short),
        .over_thr    (over_short)
    );

    // a short peak over threshold masks and restarts the long detector
    assign mask_sum        = {1'b0, trk_short_next.position}
                             + (POS_W + 1)'(cfg.window_short);
    assign mask_sat        = mask_sum[POS_W] ? {POS_W{1'b1}} : mask_sum[POS_W-1:0];
    assign mask_until_next = over_short ? mask_sat : mask_eff;
    assign long_in         = over_short ? TRACK_RESET : long_eff;

    dwpd_detector u_long (
        .cur         (in_long_reg),
        .trk_in      (long_in),
        .skip        (mask_until_next >= pos),
        .threshold   (cfg.threshold_long),
        .window      (cfg.window_long),
        .min_swing   (cfg.min_swing),
        .pos         (pos),
        .trk_out     (trk_long_next),
        .emit        (emit_long),
        .over_thr    (over_long)
    );

    assign sample_index_next = pos + POS_W'(1);

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            in_valid_next  = 1'b0;
            out_valid_next = emit_short || emit_long;
            out_pos_next   = emit_short ? OUT_W'(trk_short_next.position)
                                        : OUT_W'(trk_long_next.position);
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            sample_index_reg <= '0;
            mask_until_reg   <= '0;
            trk_short_reg    <= TRACK_RESET;
            trk_long_reg     <= TRACK_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                sample_index_reg <= sample_index_next;
                mask_until_reg   <= mask_until_next;
                trk_short_reg    <= trk_short_next;
                trk_long_reg     <= trk_long_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_short_reg    <= s_stat_short;
            in_long_reg     <= s_stat_long;
            in_new_read_reg <= s_new_read;
        end
        out_pos_reg <= out_pos_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_peak_position = out_pos_reg;

    // over_long has no consumer; only over_short drives the masking rule
    logic unused_over_long;
    assign unused_over_long = over_long;

endmodule

FILE: rtl/dwpd_checker.sv
module dwpd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [dwpd_pkg::OUT_W-1:0] m_peak_position
);
    import dwpd_pkg::*;

    // a held result keeps its position
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_peak_position))
        else $error("result changed while stalled");

    // intake stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a stalled result");

    // reset empties both registers
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // a waiting input transfer keeps its valid
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input valid dropped before transfer");

endmodule

bind dual_window_peak_detector dwpd_checker u_dwpd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_peak_position (m_peak_position)
);
